// ===== rtl/fmdd_pkg.sv =====
package fmdd_pkg;

    // width of the sample fields on the input channel
    localparam int FIELD_WIDTH    = 16;
    // sample format: one integer bit, SAMPLE_WIDTH-1 fraction bits
    localparam int SAMPLE_WIDTH   = 16;
    localparam int OUT_FRAC_BITS  = 16;
    localparam int OUT_WIDTH      = 32;
    localparam int STATUS_WIDTH   = 2;

    localparam int INT_BITS       = OUT_WIDTH - OUT_FRAC_BITS;
    localparam int PROD_WIDTH     = 2 * SAMPLE_WIDTH;
    localparam int ACC_WIDTH      = PROD_WIDTH + 2;
    localparam int TERM_WIDTH     = SAMPLE_WIDTH + 1;
    // quotient carries one extra bit below the output LSB for rounding
    localparam int QUO_WIDTH      = OUT_WIDTH + 1;
    localparam int MAC_CNT_WIDTH  = $clog2(SAMPLE_WIDTH);
    localparam int DIV_CNT_WIDTH  = $clog2(QUO_WIDTH);

    localparam logic [OUT_WIDTH-1:0] POS_LIMIT = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] NEG_LIMIT = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_NORMAL = 2'd0,
        ST_ZERO   = 2'd1,
        ST_SAT    = 2'd2
    } status_t;

    // numerator magnitude, its sign and the denominator
    typedef struct packed {
        logic                  num_neg;
        logic [PROD_WIDTH-1:0] num_mag;
        logic [PROD_WIDTH-1:0] den;
    } fmdd_frac_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        status_t              status;
    } fmdd_result_t;

endpackage

// ===== rtl/fmdd_in_if.sv =====
interface fmdd_in_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [fmdd_pkg::FIELD_WIDTH-1:0]     i_sample;
    logic signed [fmdd_pkg::FIELD_WIDTH-1:0]     q_sample;

    modport source (output valid, output i_sample, output q_sample, input ready);
    modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

// ===== rtl/fmdd_out_if.sv =====
interface fmdd_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fmdd_pkg::OUT_WIDTH-1:0]  demod_value;
    logic [fmdd_pkg::STATUS_WIDTH-1:0]      status;

    modport source (output valid, output demod_value, output status, input ready);
    modport sink   (input valid, input demod_value, input status, output ready);
endinterface

// ===== rtl/fmdd_mac.sv =====
// Bit-serial multiply-accumulate, MSB first (Horner form).
// num = cur_q*prev_i - cur_i*prev_q, den = cur_i^2 + cur_q^2
module fmdd_mac (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  cur_i,
    input  logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  cur_q,
    input  logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  prev_i,
    input  logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  prev_q,
    output logic                                      done,
    output fmdd_pkg::fmdd_frac_t                      frac
);

    logic [fmdd_pkg::SAMPLE_WIDTH-1:0]         mi_reg;
    logic [fmdd_pkg::SAMPLE_WIDTH-1:0]         mq_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  ci_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  cq_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  li_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]  lq_reg;
    logic signed [fmdd_pkg::ACC_WIDTH-1:0]     acc_den_reg;
    logic signed [fmdd_pkg::ACC_WIDTH-1:0]     acc_num_reg;
    logic signed [fmdd_pkg::ACC_WIDTH-1:0]     acc_den_next;
    logic signed [fmdd_pkg::ACC_WIDTH-1:0]     acc_num_next;
    logic [fmdd_pkg::MAC_CNT_WIDTH-1:0]        cnt_reg;
    logic                                      busy_reg;
    logic                                      first_reg;
    logic                                      done_reg;

    logic                                      bit_i;
    logic                                      bit_q;
    logic signed [fmdd_pkg::TERM_WIDTH-1:0]    term_den;
    logic signed [fmdd_pkg::TERM_WIDTH-1:0]    term_num;
    logic signed [fmdd_pkg::ACC_WIDTH-1:0]     ext_den;
    logic signed [fmdd_pkg::ACC_WIDTH-1:0]     ext_num;
    logic [fmdd_pkg::ACC_WIDTH-1:0]            num_abs;

    assign bit_i = mi_reg[fmdd_pkg::SAMPLE_WIDTH-1];
    assign bit_q = mq_reg[fmdd_pkg::SAMPLE_WIDTH-1];

    always_comb
    begin
        term_den = (bit_i ? {ci_reg[fmdd_pkg::SAMPLE_WIDTH-1], ci_reg} : '0)
                 + (bit_q ? {cq_reg[fmdd_pkg::SAMPLE_WIDTH-1], cq_reg} : '0);
        term_num = (bit_q ? {li_reg[fmdd_pkg::SAMPLE_WIDTH-1], li_reg} : '0)
                 - (bit_i ? {lq_reg[fmdd_pkg::SAMPLE_WIDTH-1], lq_reg} : '0);
        ext_den  = fmdd_pkg::ACC_WIDTH'(term_den);
        ext_num  = fmdd_pkg::ACC_WIDTH'(term_num);
        // sign bit of the multiplier carries negative weight
        acc_den_next = (acc_den_reg <<< 1) + (first_reg ? -ext_den : ext_den);
        acc_num_next = (acc_num_reg <<< 1) + (first_reg ? -ext_num : ext_num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start
                     && (cnt_reg == fmdd_pkg::MAC_CNT_WIDTH'(fmdd_pkg::SAMPLE_WIDTH - 1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= '0;
            end
            else if (busy_reg)
            begin
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == fmdd_pkg::MAC_CNT_WIDTH'(fmdd_pkg::SAMPLE_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mi_reg      <= cur_i;
            mq_reg      <= cur_q;
            ci_reg      <= cur_i;
            cq_reg      <= cur_q;
            li_reg      <= prev_i;
            lq_reg      <= prev_q;
            acc_den_reg <= '0;
            acc_num_reg <= '0;
        end
        else if (busy_reg)
        begin
            mi_reg      <= mi_reg << 1;
            mq_reg      <= mq_reg << 1;
            acc_den_reg <= acc_den_next;
            acc_num_reg <= acc_num_next;
        end
    end

    assign num_abs = acc_num_reg[fmdd_pkg::ACC_WIDTH-1] ? -acc_num_reg : acc_num_reg;

    assign done         = done_reg;
    assign frac.num_neg = acc_num_reg[fmdd_pkg::ACC_WIDTH-1];
    assign frac.num_mag = num_abs[fmdd_pkg::PROD_WIDTH-1:0];
    assign frac.den     = acc_den_reg[fmdd_pkg::PROD_WIDTH-1:0];

endmodule

// ===== rtl/fmdd_div.sv =====
// Restoring divider, one quotient bit per cycle, then round and saturate.
module fmdd_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  fmdd_pkg::fmdd_frac_t    frac,
    output logic                    done,
    output fmdd_pkg::fmdd_result_t  result
);

    typedef enum logic [2:0] {
        D_IDLE,
        D_CHECK,
        D_RUN,
        D_ROUND,
        D_PACK
    } div_state_t;

    div_state_t                          state_reg;
    logic                                neg_reg;
    logic                                sat_reg;
    logic [fmdd_pkg::PROD_WIDTH-1:0]     den_reg;
    logic [fmdd_pkg::PROD_WIDTH:0]       rem_reg;
    logic [fmdd_pkg::QUO_WIDTH-1:0]      dvd_reg;
    logic [fmdd_pkg::QUO_WIDTH-1:0]      quo_reg;
    logic [fmdd_pkg::OUT_WIDTH:0]        mag_reg;
    logic [fmdd_pkg::DIV_CNT_WIDTH-1:0]  cnt_reg;
    logic                                done_reg;
    fmdd_pkg::fmdd_result_t              result_reg;

    logic [fmdd_pkg::PROD_WIDTH:0]       trial;
    logic                                trial_ge;
    logic [fmdd_pkg::OUT_WIDTH-1:0]      limit;
    logic                                over;
    logic [fmdd_pkg::OUT_WIDTH-1:0]      lim_mag;

    always_comb
    begin
        trial    = {rem_reg[fmdd_pkg::PROD_WIDTH-1:0], dvd_reg[fmdd_pkg::QUO_WIDTH-1]};
        trial_ge = trial >= {1'b0, den_reg};
        limit    = neg_reg ? fmdd_pkg::NEG_LIMIT : fmdd_pkg::POS_LIMIT;
        over     = sat_reg || (mag_reg > {1'b0, limit});
        lim_mag  = over ? limit : mag_reg[fmdd_pkg::OUT_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= D_IDLE;
            done_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            den_reg    <= '0;
            rem_reg    <= '0;
            dvd_reg    <= '0;
            quo_reg    <= '0;
            mag_reg    <= '0;
            cnt_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == D_PACK);
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= frac.num_neg;
                        den_reg   <= frac.den;
                        rem_reg   <= (fmdd_pkg::PROD_WIDTH + 1)'(frac.num_mag >> fmdd_pkg::INT_BITS);
                        dvd_reg   <= {frac.num_mag[fmdd_pkg::INT_BITS-1:0],
                                      {(fmdd_pkg::OUT_FRAC_BITS + 1){1'b0}}};
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    // integer part too large for the output word
                    sat_reg   <= rem_reg >= {1'b0, den_reg};
                    state_reg <= (rem_reg >= {1'b0, den_reg}) ? D_PACK : D_RUN;
                end
                D_RUN:
                begin
                    rem_reg <= trial_ge ? (trial - {1'b0, den_reg}) : trial;
                    quo_reg <= {quo_reg[fmdd_pkg::QUO_WIDTH-2:0], trial_ge};
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == fmdd_pkg::DIV_CNT_WIDTH'(fmdd_pkg::QUO_WIDTH - 1))
                    begin
                        state_reg <= D_ROUND;
                    end
                end
                D_ROUND:
                begin
                    // half LSB decides, ties away from zero
                    mag_reg   <= {1'b0, quo_reg[fmdd_pkg::QUO_WIDTH-1:1]}
                               + (fmdd_pkg::OUT_WIDTH + 1)'(quo_reg[0]);
                    state_reg <= D_PACK;
                end
                D_PACK:
                begin
                    result_reg.value  <= neg_reg ? -lim_mag : lim_mag;
                    result_reg.status <= over ? fmdd_pkg::ST_SAT : fmdd_pkg::ST_NORMAL;
                    state_reg         <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/fm_derivative_discriminator.sv =====
// Channel   Dir  Payload                          Handshake
// in_ch     in   i_sample[15:0], q_sample[15:0]   valid/ready
// out_ch    out  demod_value[31:0], status[1:0]   valid/ready
//
// One item at a time: after acceptance the 16-step serial multiplier and the
// 33-step restoring divider run in turn, and the result is loaded into the
// output register. An all-zero I/Q pair skips both and is loaded as a
// zero-magnitude result.
// Reset clears the stored previous pair to zero and empties the output.
// A stalled output holds its item; in_ch.ready returns once the result is loaded.
module fm_derivative_discriminator (
    input  logic        clk,
    input  logic        rst_n,
    fmdd_in_if.sink     in_ch,
    fmdd_out_if.source  out_ch
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DIV,
        S_HOLD
    } top_state_t;

    top_state_t                                 state_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]   last_i_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]   last_q_reg;
    fmdd_pkg::fmdd_result_t                     res_reg;
    logic                                       out_valid_reg;
    fmdd_pkg::fmdd_result_t                     out_reg;

    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]   cur_i;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0]   cur_q;
    logic                                       accept;
    logic                                       zero_in;
    logic                                       mac_done;
    fmdd_pkg::fmdd_frac_t                       frac;
    logic                                       div_done;
    fmdd_pkg::fmdd_result_t                     div_result;
    logic                                       out_free;
    logic                                       load_out;

    assign cur_i    = in_ch.i_sample[fmdd_pkg::SAMPLE_WIDTH-1:0];
    assign cur_q    = in_ch.q_sample[fmdd_pkg::SAMPLE_WIDTH-1:0];
    assign accept   = in_ch.valid && in_ch.ready;
    assign zero_in  = (cur_i == '0) && (cur_q == '0);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign load_out = (state_reg == S_HOLD) && out_free;

    fmdd_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept && !zero_in),
        .cur_i  (cur_i),
        .cur_q  (cur_q),
        .prev_i (last_i_reg),
        .prev_q (last_q_reg),
        .done   (mac_done),
        .frac   (frac)
    );

    fmdd_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_done),
        .frac   (frac),
        .done   (div_done),
        .result (div_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_i_reg    <= '0;
            last_q_reg    <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_reg       <= res_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_i_reg <= cur_i;
                        last_q_reg <= cur_q;
                        if (zero_in)
                        begin
                            res_reg.value  <= '0;
                            res_reg.status <= fmdd_pkg::ST_ZERO;
                            state_reg      <= S_HOLD;
                        end
                        else
                        begin
                            state_reg <= S_MAC;
                        end
                    end
                end
                S_MAC:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg   <= div_result;
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.demod_value = out_reg.value;
    assign out_ch.status      = out_reg.status;

endmodule

// ===== rtl/fmdd_checker.sv =====
module fmdd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [fmdd_pkg::OUT_WIDTH-1:0]        demod_value,
    input logic [fmdd_pkg::STATUS_WIDTH-1:0]     status
);

    // result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(demod_value) && $stable(status))
        else $error("output payload changed while stalled");

    // one item in flight: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fmdd_pkg::ST_ZERO) |-> (demod_value == '0))
        else $error("zero magnitude item with non-zero value");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == fmdd_pkg::ST_SAT) |->
            (demod_value == fmdd_pkg::POS_LIMIT) || (demod_value == fmdd_pkg::NEG_LIMIT))
        else $error("saturated item not at a limit");

endmodule

bind fm_derivative_discriminator fmdd_checker u_fmdd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .demod_value (out_ch.demod_value),
    .status      (out_ch.status)
);

// ===== bench/fm_derivative_discriminator_tb.sv =====
module fm_derivative_discriminator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 12;
    // time for multiply/divide plus the output register, with margin
    localparam int LATENCY_CYCLES = 60;
    localparam int HOLD_OFF       = 400;

    localparam logic signed [fmdd_pkg::FIELD_WIDTH-1:0] S_MAX = 16'h7FFF;
    localparam logic signed [fmdd_pkg::FIELD_WIDTH-1:0] S_MIN = 16'h8000;

    typedef struct {
        logic signed [fmdd_pkg::OUT_WIDTH-1:0] value;
        fmdd_pkg::status_t                     status;
        int                                    item_no;
    } demod_exp_t;

    logic clk = 1'b0;
    logic rst_n;

    fmdd_in_if  in_ch ();
    fmdd_out_if out_ch ();

    fm_derivative_discriminator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    demod_exp_t                               expected_demod[$];
    logic signed [fmdd_pkg::FIELD_WIDTH-1:0]  prev_i;
    logic signed [fmdd_pkg::FIELD_WIDTH-1:0]  prev_q;
    int                                       items_sent    = 0;
    int                                       results_seen  = 0;
    int                                       error_count   = 0;
    int                                       hold_off_left = 0;
    int                                       held_cycles   = 0;
    int                                       status_seen[3];
    bit                                       send_idle_en  = 1'b1;
    bit                                       recv_idle_en  = 1'b1;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    initial
    begin
        #12ms;
        $display("Timeout: %0d items sent, %0d results seen", items_sent, results_seen);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Discriminator value for the current pair against the stored one.
    // The numerator collapses to the cross product cq*pi - ci*pq.
    function automatic demod_exp_t discriminate(input longint ci, cq, pi, pq);
        demod_exp_t r;
        longint     cross_prod;
        longint     mag_sq;
        longint     mag;
        longint     rem;
        longint     lim;
        bit         neg;
        r.item_no = 0;
        r.status  = fmdd_pkg::ST_NORMAL;
        r.value   = '0;
        cross_prod = cq * pi - ci * pq;
        mag_sq     = ci * ci + cq * cq;
        if (mag_sq == 0)
        begin
            r.status = fmdd_pkg::ST_ZERO;
            return r;
        end
        neg        = cross_prod < 0;
        cross_prod = neg ? -cross_prod : cross_prod;
        mag        = (cross_prod <<< fmdd_pkg::OUT_FRAC_BITS) / mag_sq;
        rem        = (cross_prod <<< fmdd_pkg::OUT_FRAC_BITS) % mag_sq;
        // round half away from zero on the magnitude
        if (2 * rem >= mag_sq)
            mag++;
        lim = longint'(1) <<< (fmdd_pkg::OUT_WIDTH - 1);
        if (!neg)
            lim--;
        if (mag > lim)
        begin
            mag      = lim;
            r.status = fmdd_pkg::ST_SAT;
        end
        r.value = fmdd_pkg::OUT_WIDTH'(neg ? -mag : mag);
        return r;
    endfunction

    // mostly short gaps, occasionally a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [fmdd_pkg::FIELD_WIDTH-1:0] edge_value();
        case ($urandom_range(0, 6))
            0:       return S_MIN;
            1:       return S_MIN + 16'sd1;
            2:       return -16'sd1;
            3:       return '0;
            4:       return 16'sd1;
            5:       return S_MAX - 16'sd1;
            default: return S_MAX;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_pair(input logic signed [fmdd_pkg::FIELD_WIDTH-1:0] si, sq);
        demod_exp_t e;
        int         gap;
        gap = (send_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.i_sample <= si;
        in_ch.q_sample <= sq;
        do
            @(posedge clk);
        while (!in_ch.ready);
        e = discriminate(longint'(si), longint'(sq), longint'(prev_i), longint'(prev_q));
        e.item_no = items_sent;
        expected_demod.push_back(e);
        prev_i = si;
        prev_q = sq;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic gen_pair(output logic signed [fmdd_pkg::FIELD_WIDTH-1:0] si, sq);
        int kind;
        int ni;
        int nq;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            si = 16'($urandom());
            sq = 16'($urandom());
        end
        else if (kind < 55)
        begin
            // tiny vectors: large quotients, saturation
            si = 16'(int'($urandom_range(0, 16)) - 8);
            sq = 16'(int'($urandom_range(0, 16)) - 8);
        end
        else if (kind < 62)
        begin
            si = ($urandom_range(0, 2) == 1) ? 16'($urandom()) : '0;
            sq = ($urandom_range(0, 2) == 2) ? 16'($urandom()) : '0;
        end
        else if (kind < 68)
        begin
            si = edge_value();
            sq = edge_value();
        end
        else
        begin
            // small random step from the previous pair: a slowly moving phasor
            ni = int'(prev_i) + int'($urandom_range(0, 1023)) - 512;
            nq = int'(prev_q) + int'($urandom_range(0, 1023)) - 512;
            ni = (ni > int'(S_MAX)) ? int'(S_MAX) : (ni < int'(S_MIN)) ? int'(S_MIN) : ni;
            nq = (nq > int'(S_MAX)) ? int'(S_MAX) : (nq < int'(S_MIN)) ? int'(S_MIN) : nq;
            si = 16'(ni);
            sq = 16'(nq);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_demod.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        send_pair('0, '0);              // zero magnitude straight out of reset
        send_pair(S_MAX, '0);
        send_pair('0, S_MAX);
        send_pair(S_MIN, '0);
        send_pair('0, S_MIN);
        send_pair(S_MIN, S_MIN);
        send_pair(16'sd1, '0);          // tiny vector after full scale: saturates
        send_pair('0, '0);              // zero magnitude still replaces stored pair
        send_pair('0, 16'sd1);
        send_pair(S_MIN, S_MIN);
        send_pair('0, 16'sd1);          // lands exactly on the most negative code
        send_pair(S_MIN, S_MIN);
        send_pair(16'sd1, -16'sd1);     // saturates, pair still stored
        send_pair(-16'sd1, 16'sd1);
        send_pair(S_MAX, S_MAX);
        send_pair(S_MAX, S_MIN);
        send_pair(S_MIN, S_MAX);
        send_pair(-16'sd1, -16'sd1);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(16'shAAAA, 16'sh5555);
        send_pair(-16'sd1, '0);
    endtask

    task automatic test_random_traffic(input int n);
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] si;
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] sq;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (n)
        begin
            gen_pair(si, sq);
            send_pair(si, sq);
        end
    endtask

    task automatic test_back_to_back(input int n);
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] si;
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] sq;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (n)
        begin
            gen_pair(si, sq);
            send_pair(si, sq);
        end
    endtask

    // sink stalls for a long stretch while the source keeps offering items
    task automatic test_output_hold_off();
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] si;
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] sq;
        send_idle_en  = 1'b0;
        recv_idle_en  = 1'b0;
        hold_off_left = HOLD_OFF;
        repeat (12)
        begin
            gen_pair(si, sq);
            send_pair(si, sq);
        end
    endtask

    task automatic test_drain_pause();
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] si;
        logic signed [fmdd_pkg::FIELD_WIDTH-1:0] sq;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (3)
        begin
            repeat (20)
            begin
                gen_pair(si, sq);
                send_pair(si, sq);
            end
            wait_drained();
        end
    endtask

    initial
    begin : result_sink
        int   gap_left;
        logic rdy;
        gap_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                rdy = 1'b0;
                hold_off_left--;
                held_cycles++;
            end
            else if (gap_left > 0)
            begin
                rdy = 1'b0;
                gap_left--;
            end
            else if (recv_idle_en && $urandom_range(0, 99) < 25)
            begin
                rdy      = 1'b0;
                gap_left = pick_gap() - 1;
            end
            else
            begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin : result_check
        demod_exp_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_demod.size() == 0)
            begin
                report_mismatch($sformatf("result value %0d status %0d with no item outstanding",
                                          out_ch.demod_value, out_ch.status));
            end
            else
            begin
                e = expected_demod.pop_front();
                if (out_ch.demod_value !== e.value)
                    report_mismatch($sformatf("item %0d: demod_value %0d, expected %0d",
                                              e.item_no, out_ch.demod_value, e.value));
                if (out_ch.status !== e.status)
                    report_mismatch($sformatf("item %0d: status %0d, expected %s",
                                              e.item_no, out_ch.status, e.status.name()));
                status_seen[e.status]++;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.i_sample = '0;
        in_ch.q_sample = '0;
        out_ch.ready   = 1'b0;
        prev_i         = '0;
        prev_q         = '0;
        status_seen    = '{0, 0, 0};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic(500);
        test_back_to_back(150);
        test_output_hold_off();
        test_drain_pause();
        test_random_traffic(560);

        wait_drained();
        repeat (LATENCY_CYCLES) @(negedge clk);

        $display("Sent %0d I/Q pairs, checked %0d results: %0d normal, %0d zero magnitude,",
                 items_sent, results_seen, status_seen[fmdd_pkg::ST_NORMAL],
                 status_seen[fmdd_pkg::ST_ZERO]);
        $display("%0d saturated; output held off for %0d cycles; %0d mismatches",
                 status_seen[fmdd_pkg::ST_SAT], held_cycles, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
